FILE: hdl/mtoc_pkg.sv
package mtoc_pkg;

   localparam int LEVEL_W   = 4;
   localparam int COORD_W   = 16;
   localparam int DIM_W     = 16;
   localparam int OFFSET_W  = 44;
   localparam int ERR_W     = 2;
   localparam int FMT_W     = 3;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W    = 32;

   localparam int MaxLevels = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TILE_SIZE    = 3'd2,
      CSR_PIXEL_FORMAT = 3'd3,
      CSR_HEADER_BYTES = 3'd4,
      CSR_LEVEL_COUNT  = 3'd5
   } csr_idx_type;

   localparam logic [FMT_W-1:0] FMT_R8    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RG8   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGBA8 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_R16   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_R32F  = 3'd4;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_LEVEL = 2'd1,
      ERR_COL   = 2'd2,
      ERR_ROW   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      MUL_COL_TS,
      MUL_ROW_TS,
      MUL_LEVEL,
      MUL_ROW_LW,
      MUL_PROD_TS,
      MUL_CTS_TH
   } mul_sel_type;

   typedef struct packed {
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [DIM_W-1:0]    tile_size;
      logic [FMT_W-1:0]    pixel_format;
      logic [DIM_W-1:0]    header_bytes;
      logic [COUNT_W-1:0]  level_count;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        cap_cts;
      logic        check;
      logic        idx_inc;
      logic        acc_en;
   } cmd_type;

   typedef struct packed {
      logic check_err;
      logic loop_done;
   } sts_type;

endpackage

FILE: hdl/mtoc_req_if.sv
interface mtoc_req_if;
   logic                                valid;
   logic                                ready;
   logic [mtoc_pkg::LEVEL_W-1:0]        level;
   logic [mtoc_pkg::COORD_W-1:0]        tile_col;
   logic [mtoc_pkg::COORD_W-1:0]        tile_row;

   modport source (output valid, output level, output tile_col, output tile_row,
                   input ready);
   modport sink   (input valid, input level, input tile_col, input tile_row,
                   output ready);
endinterface

FILE: hdl/mtoc_rsp_if.sv
interface mtoc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mtoc_pkg::OFFSET_W-1:0]       byte_offset;
   logic [mtoc_pkg::DIM_W-1:0]          tile_w;
   logic [mtoc_pkg::DIM_W-1:0]          tile_h;
   logic [mtoc_pkg::ERR_W-1:0]          error;

   modport source (output valid, output byte_offset, output tile_w, output tile_h,
                   output error, input ready);
   modport sink   (input valid, input byte_offset, input tile_w, input tile_h,
                   input error, output ready);
endinterface

FILE: hdl/mtoc_csr.sv
module mtoc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [mtoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mtoc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output mtoc_pkg::cfg_type                 cfg
);

   mtoc_pkg::cfg_type cfg_ff;
   mtoc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            mtoc_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            mtoc_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            mtoc_pkg::CSR_TILE_SIZE:    cfg_in.tile_size    = csr_wdata;
            mtoc_pkg::CSR_PIXEL_FORMAT:
               cfg_in.pixel_format = csr_wdata[mtoc_pkg::FMT_W-1:0];
            mtoc_pkg::CSR_HEADER_BYTES: cfg_in.header_bytes = csr_wdata;
            mtoc_pkg::CSR_LEVEL_COUNT:
               cfg_in.level_count = csr_wdata[mtoc_pkg::COUNT_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= '0;
         cfg_ff.image_height <= '0;
         cfg_ff.tile_size    <= mtoc_pkg::DIM_W'(1);
         cfg_ff.pixel_format <= mtoc_pkg::FMT_R8;
         cfg_ff.header_bytes <= '0;
         cfg_ff.level_count  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/mtoc_datapath.sv
module mtoc_datapath (
   input  logic                              clock,
   input  mtoc_pkg::cfg_type                 cfg,
   input  mtoc_pkg::cmd_type                 cmd,
   input  logic [mtoc_pkg::LEVEL_W-1:0]      req_level,
   input  logic [mtoc_pkg::COORD_W-1:0]      req_tile_col,
   input  logic [mtoc_pkg::COORD_W-1:0]      req_tile_row,
   output mtoc_pkg::sts_type                 sts,
   output logic [mtoc_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic [mtoc_pkg::DIM_W-1:0]        rsp_tile_w,
   output logic [mtoc_pkg::DIM_W-1:0]        rsp_tile_h,
   output logic [mtoc_pkg::ERR_W-1:0]        rsp_error
);

   localparam int LW = mtoc_pkg::LEVEL_W;
   localparam int CW = mtoc_pkg::COORD_W;
   localparam int DW = mtoc_pkg::DIM_W;
   localparam int OW = mtoc_pkg::OFFSET_W;
   localparam int PW = mtoc_pkg::PROD_W;

   logic [LW-1:0]      level_ff;
   logic [CW-1:0]      col_ff;
   logic [CW-1:0]      row_ff;
   logic [LW-1:0]      idx_ff;
   logic [LW-1:0]      idx_in;
   logic [PW-1:0]      cts_ff;
   logic [OW-1:0]      mul_ff;
   logic [OW-1:0]      mul_in;
   logic [OW-1:0]      acc_ff;
   logic [OW-1:0]      acc_in;
   mtoc_pkg::err_type  err_ff;
   mtoc_pkg::err_type  err_in;
   logic [DW-1:0]      tw_ff;
   logic [DW-1:0]      tw_in;
   logic [DW-1:0]      th_ff;
   logic [DW-1:0]      th_in;

   logic [DW-1:0]      ts_eff;
   logic [DW-1:0]      lw;
   logic [DW-1:0]      lh;
   logic [PW-1:0]      mul_a;
   logic [DW-1:0]      mul_b;
   logic [PW+DW-1:0]   prod;
   logic [OW-1:0]      scaled;
   logic [PW-1:0]      rts;
   logic               bad_lvl;
   logic               bad_col;
   logic               bad_row;
   logic               last_col;
   logic               last_row;

   // tile size zero behaves as one
   assign ts_eff = (cfg.tile_size == '0) ? DW'(1) : cfg.tile_size;
   assign lw     = cfg.image_width >> level_ff;
   assign lh     = cfg.image_height >> level_ff;

   always_comb begin
      case (cmd.mul_sel)
         mtoc_pkg::MUL_COL_TS: begin
            mul_a = PW'(col_ff);
            mul_b = ts_eff;
         end
         mtoc_pkg::MUL_ROW_TS: begin
            mul_a = PW'(row_ff);
            mul_b = ts_eff;
         end
         mtoc_pkg::MUL_LEVEL: begin
            mul_a = PW'(cfg.image_width >> idx_ff);
            mul_b = cfg.image_height >> idx_ff;
         end
         mtoc_pkg::MUL_ROW_LW: begin
            mul_a = PW'(row_ff);
            mul_b = lw;
         end
         mtoc_pkg::MUL_PROD_TS: begin
            mul_a = mul_ff[PW-1:0];
            mul_b = ts_eff;
         end
         mtoc_pkg::MUL_CTS_TH: begin
            mul_a = cts_ff;
            mul_b = th_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod   = PW'(mul_a) * (PW+DW)'(mul_b) + (PW+DW)'(0);
   assign mul_in = prod[OW-1:0];

   // scale the last product by bytes per pixel; unknown formats weigh nothing
   always_comb begin
      unique case (cfg.pixel_format) inside
         mtoc_pkg::FMT_R8:                     scaled = mul_ff;
         mtoc_pkg::FMT_RG8, mtoc_pkg::FMT_R16:  scaled = mul_ff << 1;
         mtoc_pkg::FMT_RGBA8, mtoc_pkg::FMT_R32F: scaled = mul_ff << 2;
         default:                              scaled = '0;
      endcase
   end

   assign acc_in = acc_ff + scaled;
   assign idx_in = idx_ff + LW'(1);

   // a column is inside the level exactly when col * ts < level width
   assign rts      = mul_ff[PW-1:0];
   assign bad_lvl  = ({1'b0, level_ff} >= cfg.level_count) ||
                     ({1'b0, level_ff} >= mtoc_pkg::COUNT_W'(mtoc_pkg::MaxLevels));
   assign bad_col  = cts_ff >= PW'(lw);
   assign bad_row  = rts >= PW'(lh);
   assign last_col = ({1'b0, cts_ff} + (PW+1)'(ts_eff)) >= (PW+1)'(lw);
   assign last_row = ({1'b0, rts} + (PW+1)'(ts_eff)) >= (PW+1)'(lh);

   always_comb begin
      tw_in = '0;
      th_in = '0;
      if (bad_lvl) begin
         err_in = mtoc_pkg::ERR_LEVEL;
      end else if (bad_col) begin
         err_in = mtoc_pkg::ERR_COL;
      end else if (bad_row) begin
         err_in = mtoc_pkg::ERR_ROW;
      end else begin
         err_in = mtoc_pkg::ERR_OK;
         tw_in  = last_col ? (lw - cts_ff[DW-1:0]) : ts_eff;
         th_in  = last_row ? (lh - rts[DW-1:0]) : ts_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         level_ff <= req_level;
         col_ff   <= req_tile_col;
         row_ff   <= req_tile_row;
         idx_ff   <= '0;
         acc_ff   <= OW'(cfg.header_bytes);
      end else begin
         if (cmd.idx_inc) idx_ff <= idx_in;
         if (cmd.acc_en)  acc_ff <= acc_in;
      end
      if (cmd.mul_en)  mul_ff <= mul_in;
      if (cmd.cap_cts) cts_ff <= mul_ff[PW-1:0];
      if (cmd.check) begin
         err_ff <= err_in;
         tw_ff  <= tw_in;
         th_ff  <= th_in;
      end
   end

   assign sts.check_err = (err_in != mtoc_pkg::ERR_OK);
   assign sts.loop_done = (idx_ff == level_ff);

   assign rsp_byte_offset = (err_ff == mtoc_pkg::ERR_OK) ? acc_ff : '0;
   assign rsp_tile_w      = tw_ff;
   assign rsp_tile_h      = th_ff;
   assign rsp_error       = err_ff;

endmodule

FILE: hdl/mtoc_ctrl.sv
module mtoc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mtoc_pkg::sts_type sts,
   output mtoc_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MCOL,
      S_MROW,
      S_CHECK,
      S_LVM,
      S_LVA,
      S_RTS,
      S_ADDR,
      S_ADDC,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_accept;

   assign req_accept = req_valid && req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff     <= S_MCOL;
                  req_ready_ff <= 1'b0;
               end
            end
            S_MCOL:  state_ff <= S_MROW;
            S_MROW:  state_ff <= S_CHECK;
            S_CHECK: begin
               if (sts.check_err) begin
                  state_ff     <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_LVM;
               end
            end
            S_LVM:   state_ff <= sts.loop_done ? S_RTS : S_LVA;
            S_LVA:   state_ff <= S_LVM;
            S_RTS:   state_ff <= S_ADDR;
            S_ADDR:  state_ff <= S_ADDC;
            S_ADDC: begin
               state_ff     <= S_OUT;
               rsp_valid_ff <= 1'b1;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = mtoc_pkg::MUL_COL_TS;
      unique case (state_ff)
         S_IDLE:  cmd.load = req_accept;
         S_MCOL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mtoc_pkg::MUL_COL_TS;
         end
         S_MROW: begin
            cmd.cap_cts = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mtoc_pkg::MUL_ROW_TS;
         end
         S_CHECK: cmd.check = 1'b1;
         S_LVM: begin
            // level sizes below the request first, then the row term
            cmd.mul_en = 1'b1;
            if (sts.loop_done) begin
               cmd.mul_sel = mtoc_pkg::MUL_ROW_LW;
            end else begin
               cmd.mul_sel = mtoc_pkg::MUL_LEVEL;
               cmd.idx_inc = 1'b1;
            end
         end
         S_LVA:   cmd.acc_en = 1'b1;
         S_RTS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mtoc_pkg::MUL_PROD_TS;
         end
         S_ADDR: begin
            cmd.acc_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mtoc_pkg::MUL_CTS_TH;
         end
         S_ADDC:  cmd.acc_en = 1'b1;
         S_OUT:   ;
         default: ;
      endcase
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/mip_tile_offset_calc_unit.sv
// Channel    Direction  Transaction
// req_bus    in         level, tile_col, tile_row
// rsp_bus    out        byte_offset, tile_w, tile_h, error
// csr_*      in         write enable, register index, write data (no read-back)
//
// One transaction at a time. A request is answered after the walk over its lower
// levels, or straight after the checks when one fails; each lower level takes a
// multiply step and an accumulate step on the shared 32x16 multiplier.
// req_bus.ready returns in the cycle after the response transaction completes.
// Reset is synchronous; the response holds while rsp_bus.ready is low.
module mip_tile_offset_calc_unit (
   input  logic                              clock,
   input  logic                              reset,
   mtoc_req_if.sink                          req_bus,
   mtoc_rsp_if.source                        rsp_bus,
   input  logic                              csr_wen,
   input  logic [mtoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mtoc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   mtoc_pkg::cfg_type cfg;
   mtoc_pkg::cmd_type cmd;
   mtoc_pkg::sts_type sts;

   mtoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mtoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtoc_datapath u_datapath (
      .clock           (clock),
      .cfg             (cfg),
      .cmd             (cmd),
      .req_level       (req_bus.level),
      .req_tile_col    (req_bus.tile_col),
      .req_tile_row    (req_bus.tile_row),
      .sts             (sts),
      .rsp_byte_offset (rsp_bus.byte_offset),
      .rsp_tile_w      (rsp_bus.tile_w),
      .rsp_tile_h      (rsp_bus.tile_h),
      .rsp_error       (rsp_bus.error)
   );

endmodule

FILE: tb/sv/tb_mip_tile_offset_calc_unit.sv
`timescale 1ns / 1ps

module tb_mip_tile_offset_calc_unit;
   import mtoc_pkg::*;

   localparam logic [FMT_W-1:0] FMT_UNKNOWN = 3'd7;
   localparam int unsigned REQ_TOTAL = 1550;
   localparam int unsigned ITEMS_PER_SETUP = 120;

   typedef struct {
      logic [OFFSET_W-1:0] byte_offset;
      logic [DIM_W-1:0]    tile_w;
      logic [DIM_W-1:0]    tile_h;
      err_type             error;
   } tile_info_type;

   class tile_offset_checker;
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [DIM_W-1:0]   tile_size;
      logic [FMT_W-1:0]   pixel_format;
      logic [DIM_W-1:0]   header_bytes;
      logic [COUNT_W-1:0] level_count;
      tile_info_type      pending_tiles[$];
      int unsigned        errors;
      int unsigned        code_seen[4];

      function new();
         image_width  = '0;
         image_height = '0;
         tile_size    = 1;
         pixel_format = FMT_R8;
         header_bytes = '0;
         level_count  = '0;
         errors = 0;
         foreach (code_seen[k]) code_seen[k] = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:  image_width  = data;
            CSR_IMAGE_HEIGHT: image_height = data;
            CSR_TILE_SIZE:    tile_size    = data;
            CSR_PIXEL_FORMAT: pixel_format = data[FMT_W-1:0];
            CSR_HEADER_BYTES: header_bytes = data;
            CSR_LEVEL_COUNT:  level_count  = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned level_limit();
         return (level_count < MaxLevels) ? level_count : MaxLevels;
      endfunction

      // tile size zero acts as one
      function longint unsigned span_tiles(longint unsigned len);
         longint unsigned ts;
         ts = (tile_size == 0) ? 1 : tile_size;
         return (len + ts - 1) / ts;
      endfunction

      function tile_info_type predict_tile(logic [LEVEL_W-1:0] level,
                                           logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         tile_info_type   res;
         longint unsigned ts, ps, wd, hd, lw, lh, nx, ny, tw, th, pos;
         res.byte_offset = '0;
         res.tile_w = '0;
         res.tile_h = '0;
         res.error = ERR_OK;
         ts = (tile_size == 0) ? 1 : tile_size;
         case (pixel_format)
            FMT_R8:             ps = 1;
            FMT_RG8, FMT_R16:   ps = 2;
            FMT_RGBA8, FMT_R32F: ps = 4;
            default:            ps = 0;
         endcase
         if (level >= level_limit()) begin
            res.error = ERR_LEVEL;
            return res;
         end
         wd = image_width;
         hd = image_height;
         lw = wd >> level;
         lh = hd >> level;
         nx = span_tiles(lw);
         ny = span_tiles(lh);
         // first failing check wins: column before row
         if (col >= nx) begin
            res.error = ERR_COL;
            return res;
         end
         if (row >= ny) begin
            res.error = ERR_ROW;
            return res;
         end
         tw = (col == nx - 1) ? lw - (nx - 1) * ts : ts;
         th = (row == ny - 1) ? lh - (ny - 1) * ts : ts;
         pos = header_bytes;
         for (int unsigned i = 0; i < level; i++)
            pos += (wd >> i) * (hd >> i) * ps;
         pos += longint'(row) * lw * ts * ps;
         pos += longint'(col) * ts * th * ps;
         res.byte_offset = pos[OFFSET_W-1:0];
         res.tile_w = tw[DIM_W-1:0];
         res.tile_h = th[DIM_W-1:0];
         return res;
      endfunction

      function void note_request(logic [LEVEL_W-1:0] level,
                                 logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         pending_tiles.push_back(predict_tile(level, col, row));
      endfunction

      function void check_response(tile_info_type got);
         tile_info_type want;
         if (pending_tiles.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         want = pending_tiles.pop_front();
         code_seen[want.error]++;
         if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected 0x%0h, got 0x%0h", want.byte_offset, got.byte_offset);
            errors++;
         end
         if (got.tile_w !== want.tile_w) begin
            $error("tile_w: expected %0d, got %0d", want.tile_w, got.tile_w);
            errors++;
         end
         if (got.tile_h !== want.tile_h) begin
            $error("tile_h: expected %0d, got %0d", want.tile_h, got.tile_h);
            errors++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, got.error);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mtoc_req_if req_bus ();
   mtoc_rsp_if rsp_bus ();

   tile_offset_checker board;
   tile_info_type      seen_tile;
   bit                 steady;
   int unsigned        sent;
   int unsigned        setups;

   mip_tile_offset_calc_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 15);
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_request(req_bus.level, req_bus.tile_col, req_bus.tile_row);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_tile.byte_offset = rsp_bus.byte_offset;
         seen_tile.tile_w = rsp_bus.tile_w;
         seen_tile.tile_h = rsp_bus.tile_h;
         seen_tile.error = err_type'(rsp_bus.error);
         board.check_response(seen_tile);
      end
   end

   task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [DIM_W-1:0] ts,
                            logic [FMT_W-1:0] fmt, logic [DIM_W-1:0] hdr,
                            logic [COUNT_W-1:0] lc);
      csr_idx_type           idx[6];
      logic [CSR_DATA_W-1:0] val[6];
      idx = '{CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_TILE_SIZE,
              CSR_PIXEL_FORMAT, CSR_HEADER_BYTES, CSR_LEVEL_COUNT};
      val = '{w, h, ts, CSR_DATA_W'(fmt), hdr, CSR_DATA_W'(lc)};
      for (int k = 0; k < 6; k++) begin
         csr_wen   <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         board.set_register(idx[k], val[k]);
      end
      csr_wen <= 1'b0;
      setups++;
   endtask

   task automatic send_request(logic [LEVEL_W-1:0] lvl, logic [COORD_W-1:0] col,
                               logic [COORD_W-1:0] row);
      int unsigned gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.level    <= lvl;
      req_bus.tile_col <= col;
      req_bus.tile_row <= row;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // drop valid and hold until every response is back; the first edge lets the
   // monitor record the last accepted request
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_tiles.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly in range, with some last tiles and some one past the end
   function automatic logic [COORD_W-1:0] pick_index(longint unsigned n);
      if (n == 0) return COORD_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0, 1:    return COORD_W'(n - 1);
         2:       return COORD_W'(n);
         default: return COORD_W'($urandom_range(0, 32'(n - 1)));
      endcase
   endfunction

   task automatic send_random_item();
      int unsigned        lim;
      logic [LEVEL_W-1:0] lvl;
      logic [COORD_W-1:0] col, row;
      lim = board.level_limit();
      lvl = LEVEL_W'($urandom_range(0, 15));
      col = COORD_W'($urandom);
      row = COORD_W'($urandom);
      if (lim != 0 && $urandom_range(0, 99) < 80) begin
         lvl = LEVEL_W'($urandom_range(0, lim - 1));
         col = pick_index(board.span_tiles(board.image_width >> lvl));
         row = pick_index(board.span_tiles(board.image_height >> lvl));
      end
      send_request(lvl, col, row);
   endtask

   task automatic random_setup(int unsigned phase);
      logic [DIM_W-1:0]   w, h, ts;
      logic [COUNT_W-1:0] lc;
      if (phase == 0) begin
         configure(16'hFFFF, 16'hFFFF, 16'd1, FMT_R32F, 16'hFFFF, 5'd16);
         return;
      end
      if (phase == 1) begin
         configure(16'd1, 16'hFFFF, 16'hFFFF, FMT_R8, 16'd0, 5'd1);
         return;
      end
      w = ($urandom_range(0, 1) != 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 400));
      h = ($urandom_range(0, 1) != 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 400));
      case ($urandom_range(0, 9))
         0:       ts = '0;
         1:       ts = DIM_W'($urandom_range(1, 65535));
         2:       ts = DIM_W'(1) << $urandom_range(0, 15);
         default: ts = DIM_W'($urandom_range(1, 48));
      endcase
      lc = ($urandom_range(0, 9) == 0) ? COUNT_W'(0) : COUNT_W'($urandom_range(1, 16));
      configure(w, h, ts, FMT_W'($urandom_range(0, 4)), DIM_W'($urandom), lc);
   endtask

   initial begin
      int unsigned phase;
      board = new();
      steady = 1'b0;
      sent = 0;
      setups = 0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.level = '0;
      req_bus.tile_col = '0;
      req_bus.tile_row = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset no level is stored
      send_request(4'd0, 16'd0, 16'd0);
      send_request(4'd15, 16'hFFFF, 16'hFFFF);
      settle();

      configure(16'hFFFF, 16'hFFFF, 16'd1, FMT_R32F, 16'hFFFF, 5'd16);
      send_request(4'd0, 16'd0, 16'd0);
      send_request(4'd15, 16'd0, 16'd0);
      send_request(4'd15, 16'd1, 16'd0);
      send_request(4'd0, 16'hFFFE, 16'hFFFE);
      send_request(4'd0, 16'hFFFF, 16'd0);
      send_request(4'd0, 16'd0, 16'hFFFF);
      send_request(4'd3, 16'd100, 16'd200);
      settle();

      // empty levels: zero width fails on column first, zero height on row
      configure(16'd0, 16'd0, 16'd4, FMT_RG8, 16'd7, 5'd4);
      send_request(4'd0, 16'd0, 16'd0);
      settle();
      configure(16'd8, 16'd0, 16'd4, FMT_R16, 16'd7, 5'd4);
      send_request(4'd0, 16'd0, 16'd0);
      send_request(4'd3, 16'd0, 16'd0);
      send_request(4'd4, 16'd0, 16'd0);
      settle();

      // zero tile size
      configure(16'd100, 16'd37, 16'd0, FMT_R8, 16'd12, 5'd3);
      send_request(4'd1, 16'd49, 16'd18);
      send_request(4'd2, 16'd24, 16'd8);
      send_request(4'd0, 16'd99, 16'd36);
      settle();

      // narrow edge tiles
      configure(16'd1000, 16'd600, 16'd64, FMT_RGBA8, 16'd100, 5'd10);
      send_request(4'd0, 16'd15, 16'd9);
      send_request(4'd2, 16'd3, 16'd2);
      send_request(4'd9, 16'd0, 16'd0);
      send_request(4'd10, 16'd0, 16'd0);
      send_request(4'd1, 16'd8, 16'd5);
      settle();

      configure(16'd300, 16'd200, 16'd32, FMT_UNKNOWN, 16'd500, 5'd5);
      send_request(4'd1, 16'd2, 16'd3);
      send_request(4'd0, 16'd9, 16'd6);
      settle();

      phase = 0;
      while (sent < REQ_TOTAL) begin
         random_setup(phase);
         steady = (phase == 5);
         repeat (ITEMS_PER_SETUP) send_random_item();
         settle();
         phase++;
      end
      steady = 1'b0;
      repeat (40) @(posedge clock);

      $display("Sent %0d requests under %0d register settings.", sent, setups);
      $display("Responses: %0d in range, %0d bad level, %0d bad column, %0d bad row.",
               board.code_seen[ERR_OK], board.code_seen[ERR_LEVEL],
               board.code_seen[ERR_COL], board.code_seen[ERR_ROW]);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: %0d requests sent, %0d responses outstanding",
               sent, board.pending_tiles.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
